[hw/rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, opcodes and the record that moves along the divider chain.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WIDTH      = 32;
   localparam int KW         = $clog2(WIDTH);
   localparam int REQ_DATA_W = ((4 * WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * WIDTH + 7) / 8) * 8;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_DIV    = 3'd3,
      OP_GT     = 3'd4,
      OP_LT     = 3'd5,
      OP_EQ     = 3'd6,
      OP_REDUCE = 3'd7
   } op_type;

   // One restoring-division step works on two dividends that share a divisor.
   typedef struct packed {
      logic             valid;
      logic [WIDTH-1:0] divisor;
      logic [WIDTH-1:0] rem0;
      logic [WIDTH-1:0] dq0;
      logic [WIDTH-1:0] rem1;
      logic [WIDTH-1:0] dq1;
   } cell_data_type;

endpackage

[hw/rtl/rau_div_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// One registered restoring-division step for two lanes with a common divisor.
// ----------------------------------------------------------------------------
module rau_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rau_pkg::cell_data_type cell_i,
   output rau_pkg::cell_data_type cell_o
);
   import rau_pkg::*;

   cell_data_type cell_ff;
   cell_data_type cell_in;
   logic [WIDTH:0] trial0;
   logic [WIDTH:0] trial1;
   logic           take0;
   logic           take1;

   // Shift the next dividend bit into the remainder, subtract where it fits.
   always_comb begin
      trial0 = {cell_i.rem0, cell_i.dq0[WIDTH-1]};
      trial1 = {cell_i.rem1, cell_i.dq1[WIDTH-1]};
      take0  = trial0 >= {1'b0, cell_i.divisor};
      take1  = trial1 >= {1'b0, cell_i.divisor};
      cell_in         = cell_i;
      cell_in.valid   = cell_i.valid && !reset;
      cell_in.rem0    = take0 ? WIDTH'(trial0 - {1'b0, cell_i.divisor})
                              : trial0[WIDTH-1:0];
      cell_in.rem1    = take1 ? WIDTH'(trial1 - {1'b0, cell_i.divisor})
                              : trial1[WIDTH-1:0];
      cell_in.dq0     = {cell_i.dq0[WIDTH-2:0], take0};
      cell_in.dq1     = {cell_i.dq1[WIDTH-2:0], take1};
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule

[hw/rtl/rau_div_chain.sv]
// ----------------------------------------------------------------------------
// Divider chain
// A row of WIDTH division cells; the quotient leaves the last cell.
// ----------------------------------------------------------------------------
module rau_div_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  rau_pkg::cell_data_type chain_i,
   output rau_pkg::cell_data_type chain_o
);
   import rau_pkg::*;

   cell_data_type link [WIDTH+1];

   assign link[0] = chain_i;

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      rau_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cell_i (link[i]),
         .cell_o (link[i+1])
      );
   end

   assign chain_o = link[WIDTH];

endmodule

[hw/rtl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide, compare and reduce signed fractions.
// ----------------------------------------------------------------------------
// The block takes one item on the req_ channel: the opcode in req_tuser and
// the fractions a and b in req_tdata. It returns exactly one item on the
// rsp_ channel: the result fraction in rsp_tdata and the compare and overflow
// flags in rsp_tuser. One item is worked on at a time.
// Add and subtract take three passes through the single shared multiplier,
// the other arithmetic and compare operations two; a final step then loads
// the result into the output register, and the block goes back to idle for
// the next item.
// Reduce first finds the gcd with a binary gcd loop, one shift or subtract
// per cycle, and then sends both magnitudes through a row of WIDTH division
// cells, one quotient bit per cell, plus two more steps; that loop and the
// cell row set its rate.
// A finished result sits in the output register, and a new item is taken
// while it waits; the next result waits in turn until rsp_tready is seen.
// Reset is synchronous and active high; it empties the block and the
// divider row at once, so the first item is accepted in the next cycle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // a_num, a_den, b_num, b_den from the lowest bit up
   input  logic [rau_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [2:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // res_num, res_den from the lowest bit up
   output logic [rau_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // cmp_true, overflow from the lowest bit up
   output logic [1:0]                     rsp_tuser
);
   import rau_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIN,
      ST_GCD,
      ST_DIVW,
      ST_RED
   } state_type;

   state_type              state_ff;
   op_type                 op_ff;
   logic signed [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [1:0]             step_ff;
   logic signed [2*WIDTH-1:0] p1_ff, p2_ff, p3_ff;
   logic [WIDTH-1:0]       u_ff, v_ff;
   logic [KW-1:0]          k_ff;
   logic [WIDTH-1:0]       q0_ff, q1_ff;
   logic [WIDTH-1:0]       res_num_ff, res_den_ff;
   logic                   cmp_ff, ovf_ff, rsp_valid_ff;
   logic                   rsp_valid_in;

   logic signed [WIDTH-1:0]   a_den_in, b_den_in, mul_a, mul_b;
   logic signed [2*WIDTH-1:0] prod;
   logic [1:0]                last_step;
   logic                      out_free;
   cell_data_type             chain_in, chain_out;

   logic [WIDTH-1:0] sum, den3, den2, rn_red, rd_red;
   logic             ovf_sum;

   function automatic logic fits(input logic signed [2*WIDTH-1:0] p);
      return (&p[2*WIDTH-1:WIDTH-1]) || ~(|p[2*WIDTH-1:WIDTH-1]);
   endfunction

   function automatic logic [WIDTH-1:0] mag(input logic signed [WIDTH-1:0] x);
      return x[WIDTH-1] ? WIDTH'(-x) : x;
   endfunction

   function automatic logic [WIDTH-1:0] one_if_zero(input logic [WIDTH-1:0] x);
      return (x == '0) ? WIDTH'(1) : x;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The output register loads a finished result, or empties once taken.
   assign rsp_valid_in = ((state_ff == ST_FIN || state_ff == ST_RED) && out_free) ? 1'b1
                                                                   : (rsp_valid_ff && !rsp_tready);

   // Zero denominators are taken as one on the way in.
   assign a_den_in = (req_tdata[2*WIDTH-1:WIDTH] == '0) ? WIDTH'(1)
                                                        : req_tdata[2*WIDTH-1:WIDTH];
   assign b_den_in = (req_tdata[4*WIDTH-1:3*WIDTH] == '0) ? WIDTH'(1)
                                                          : req_tdata[4*WIDTH-1:3*WIDTH];

   assign last_step = (op_ff == OP_ADD || op_ff == OP_SUB) ? 2'd2 : 2'd1;

   // Operand selection for the shared multiplier, one product per cycle.
   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      case (op_ff)
         OP_ADD, OP_SUB: begin
            case (step_ff)
               2'd0:    begin mul_a = an_ff; mul_b = bd_ff; end
               2'd1:    begin mul_a = bn_ff; mul_b = ad_ff; end
               default: begin mul_a = ad_ff; mul_b = bd_ff; end
            endcase
         end
         OP_MUL: begin
            mul_a = (step_ff == 2'd0) ? an_ff : ad_ff;
            mul_b = (step_ff == 2'd0) ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = (step_ff == 2'd0) ? an_ff : ad_ff;
            mul_b = (step_ff == 2'd0) ? bd_ff : bn_ff;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Final sum or difference of the low product halves.
   always_comb begin
      if (op_ff == OP_SUB) begin
         sum     = WIDTH'(p1_ff[WIDTH-1:0] - p2_ff[WIDTH-1:0]);
         ovf_sum = (p1_ff[WIDTH-1] != p2_ff[WIDTH-1]) && (sum[WIDTH-1] != p1_ff[WIDTH-1]);
      end else begin
         sum     = WIDTH'(p1_ff[WIDTH-1:0] + p2_ff[WIDTH-1:0]);
         ovf_sum = (p1_ff[WIDTH-1] == p2_ff[WIDTH-1]) && (sum[WIDTH-1] != p1_ff[WIDTH-1]);
      end
      den3 = one_if_zero(p3_ff[WIDTH-1:0]);
      den2 = one_if_zero(p2_ff[WIDTH-1:0]);
   end

   // Reduce: quotients get back the signs of the original parts, and a zero numerator gets a denominator of one.
   always_comb begin
      rn_red = an_ff[WIDTH-1] ? WIDTH'(-q0_ff) : q0_ff;
      rd_red = ad_ff[WIDTH-1] ? WIDTH'(-q1_ff) : q1_ff;
      if (rn_red == '0) begin
         rd_red = WIDTH'(1);
      end
   end

   // The gcd is ready once u has reached zero; launch both divisions then.
   always_comb begin
      chain_in         = '0;
      chain_in.valid   = (state_ff == ST_GCD) && (u_ff == '0);
      chain_in.divisor = v_ff << k_ff;
      chain_in.dq0     = mag(an_ff);
      chain_in.dq1     = mag(ad_ff);
   end

   rau_div_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .chain_i (chain_in),
      .chain_o (chain_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff   <= op_type'(req_tuser);
                  an_ff   <= req_tdata[WIDTH-1:0];
                  ad_ff   <= a_den_in;
                  bn_ff   <= req_tdata[3*WIDTH-1:2*WIDTH];
                  bd_ff   <= b_den_in;
                  u_ff    <= mag(req_tdata[WIDTH-1:0]);
                  v_ff    <= mag(a_den_in);
                  k_ff    <= '0;
                  step_ff <= 2'd0;
                  state_ff <= (op_type'(req_tuser) == OP_REDUCE) ? ST_GCD : ST_MUL;
               end
            end
            ST_MUL: begin
               case (step_ff)
                  2'd0:    p1_ff <= prod;
                  2'd1:    p2_ff <= prod;
                  default: p3_ff <= prod;
               endcase
               step_ff <= step_ff + 2'd1;
               if (step_ff == last_step) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  case (op_ff)
                     OP_ADD, OP_SUB: begin
                        res_num_ff <= sum;
                        res_den_ff <= den3;
                        cmp_ff     <= 1'b0;
                        ovf_ff     <= !fits(p1_ff) || !fits(p2_ff) || !fits(p3_ff) ||
                                      ovf_sum;
                     end
                     OP_MUL, OP_DIV: begin
                        res_num_ff <= p1_ff[WIDTH-1:0];
                        res_den_ff <= den2;
                        cmp_ff     <= 1'b0;
                        ovf_ff     <= !fits(p1_ff) || !fits(p2_ff);
                     end
                     default: begin
                        res_num_ff <= '0;
                        res_den_ff <= WIDTH'(1);
                        ovf_ff     <= 1'b0;
                        cmp_ff     <= (op_ff == OP_GT) ? (p1_ff > p2_ff) :
                                      (op_ff == OP_LT) ? (p1_ff < p2_ff) : (p1_ff == p2_ff);
                     end
                  endcase
                  state_ff <= ST_IDLE;
               end
            end
            ST_GCD: begin
               // Binary gcd: strip common twos, then subtract odd from odd.
               if (u_ff == '0) begin
                  state_ff <= ST_DIVW;
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + KW'(1);
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ff >= v_ff) begin
                  u_ff <= (u_ff - v_ff) >> 1;
               end else begin
                  v_ff <= (v_ff - u_ff) >> 1;
               end
            end
            ST_DIVW: begin
               if (chain_out.valid) begin
                  q0_ff    <= chain_out.dq0;
                  q1_ff    <= chain_out.dq1;
                  state_ff <= ST_RED;
               end
            end
            ST_RED: begin
               if (out_free) begin
                  res_num_ff   <= rn_red;
                  res_den_ff   <= rd_red;
                  cmp_ff       <= 1'b0;
                  ovf_ff       <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({res_den_ff, res_num_ff});
   assign rsp_tuser  = {ovf_ff, cmp_ff};

endmodule

[bench/rational_arithmetic_unit_tb.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction items with random gaps, predicts each result with an
// independent arithmetic model and checks every returned item in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
   import rau_pkg::*;

   typedef struct {
      op_type            op;
      logic signed [31:0] an, ad, bn, bd;
   } frac_item_type;

   typedef struct {
      logic [31:0] num, den;
      logic        cmp, ovf;
   } frac_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   frac_item_type   pending_items[$];
   frac_result_type expected_results[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              send_gap = 0;
   int              recv_gap = 0;
   bit              sending = 1'b0;
   bit              hold_sender = 1'b0;
   bit              req_tready_seen = 1'b0;

   rational_arithmetic_unit dut (.*);

   always #6 clock = ~clock;

   // Signed 64-bit value that does not fit in 32 bits.
   function automatic bit wide(input logic signed [63:0] v);
      return v != {{32{v[31]}}, v[31:0]};
   endfunction

   function automatic logic [31:0] euclid_gcd(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic frac_result_type rational_result(input frac_item_type it);
      frac_result_type res;
      logic signed [31:0]  ad, bd, x, y, r;
      logic signed [63:0]  p1, p2, pd;
      logic [31:0]         ma, md, g, qn, qd;
      res = '{num: 32'd0, den: 32'd1, cmp: 1'b0, ovf: 1'b0};
      ad = (it.ad == 0) ? 32'sd1 : it.ad;
      bd = (it.bd == 0) ? 32'sd1 : it.bd;
      case (it.op)
         OP_ADD, OP_SUB: begin
            p1 = 64'(it.an) * 64'(bd);
            p2 = 64'(it.bn) * 64'(ad);
            pd = 64'(ad) * 64'(bd);
            res.ovf = wide(p1) | wide(p2) | wide(pd);
            x = p1[31:0];
            y = p2[31:0];
            if (it.op == OP_ADD) begin
               r = x + y;
               if (x[31] == y[31] && r[31] != x[31]) res.ovf = 1'b1;
            end else begin
               r = x - y;
               if (x[31] != y[31] && r[31] != x[31]) res.ovf = 1'b1;
            end
            res.num = r;
            res.den = pd[31:0];
         end
         OP_MUL, OP_DIV: begin
            // Divide multiplies by the flipped second fraction.
            p1 = 64'(it.an) * 64'((it.op == OP_MUL) ? it.bn : bd);
            pd = 64'(ad) * 64'((it.op == OP_MUL) ? bd : it.bn);
            res.ovf = wide(p1) | wide(pd);
            res.num = p1[31:0];
            res.den = pd[31:0];
         end
         OP_GT, OP_LT, OP_EQ: begin
            p1 = 64'(it.an) * 64'(bd);
            p2 = 64'(ad) * 64'(it.bn);
            res.cmp = (it.op == OP_GT) ? (p1 > p2) : (it.op == OP_LT) ? (p1 < p2) : (p1 == p2);
         end
         default: begin
            ma = it.an[31] ? -it.an : it.an;
            md = ad[31] ? -ad : ad;
            g = euclid_gcd(ma, md);
            if (g == 0) g = 1;
            qn = ma / g;
            qd = md / g;
            res.num = it.an[31] ? -qn : qn;
            res.den = ad[31] ? -qd : qd;
            if (res.num == 0) res.den = 1;
         end
      endcase
      if (it.op <= OP_DIV && res.den == 0) res.den = 1;
      return res;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         3: return $urandom_range(0, 40) - 20;
         4: return $urandom_range(0, 2000) - 1000;
         5: return $urandom_range(0, 200000) - 100000;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_item(input op_type op, input logic [31:0] an, input logic [31:0] ad,
                           input logic [31:0] bn, input logic [31:0] bd);
      frac_item_type it;
      it.op = op; it.an = an; it.ad = ad; it.bn = bn; it.bd = bd;
      pending_items.push_back(it);
   endtask

   // The driver presents one item at a time and waits a random gap before each.
   always @(negedge clock) begin
      if (!reset) begin
         if (sending && req_tready_seen) begin
            sending = 1'b0;
            send_gap = $urandom_range(0, 10);
         end
         if (!sending) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (!hold_sender && pending_items.size() > 0) begin
               frac_item_type it;
               it = pending_items.pop_front();
               expected_results.push_back(rational_result(it));
               req_tdata <= {it.bd, it.bn, it.ad, it.an};
               req_tuser <= it.op;
               req_tvalid <= 1'b1;
               sending = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Handshake on the request side is sampled at the rising edge.
   always @(posedge clock) req_tready_seen <= req_tvalid && req_tready;

   // The receiver throttles rsp_tready with its own random gaps.
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // The monitor checks every accepted result against the oldest prediction.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         frac_result_type want;
         recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (expected_results.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("unexpected result item: data %h flags %b", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[31:0] !== want.num || rsp_tdata[63:32] !== want.den ||
                rsp_tuser[0] !== want.cmp || rsp_tuser[1] !== want.ovf) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("want num %h den %h cmp %b ovf %b, got num %h den %h cmp %b ovf %b",
                           want.num, want.den, want.cmp, want.ovf, rsp_tdata[31:0],
                           rsp_tdata[63:32], rsp_tuser[0], rsp_tuser[1]);
            end
         end
      end
      if (cycle_count > 1_500_000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      op_type op;
      // Directed items: field extremes, every operation, zero denominators,
      // overflowing products, a zero gcd and a zero numerator in reduce.
      for (int k = 0; k < 8; k++) begin
         op = op_type'(k);
         add_item(op, 32'sd3, 32'sd4, -32'sd5, 32'sd6);
      end
      add_item(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      add_item(OP_SUB, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1);
      add_item(OP_MUL, 32'd5, 32'd0, 32'd7, 32'd0);
      add_item(OP_DIV, 32'd5, 32'd3, 32'd0, 32'd2);
      add_item(OP_MUL, 32'd1, 32'h0001_0000, 32'd1, 32'h0001_0000);
      add_item(OP_GT, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      add_item(OP_LT, -32'sd1, 32'd2, 32'd1, -32'sd2);
      add_item(OP_EQ, 32'd2, 32'd4, 32'd1, 32'd2);
      add_item(OP_REDUCE, 32'd0, 32'd0, 32'hffff_ffff, 32'hffff_ffff);
      add_item(OP_REDUCE, 32'd0, 32'd17, 32'd0, 32'd0);
      add_item(OP_REDUCE, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
      add_item(OP_REDUCE, -32'sd12, 32'd18, 32'd0, 32'd0);
      add_item(OP_REDUCE, 32'h8000_0000, 32'd6, 32'd0, 32'd0);
      add_item(OP_REDUCE, 32'h7fff_ffff, -32'sd1, 32'd0, 32'd0);
      for (int k = 0; k < 1600; k++)
         add_item(op_type'($urandom_range(0, 7)), pick_value(), pick_value(), pick_value(),
                  pick_value());
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Pause the sender once until the block has drained completely.
      wait (pending_items.size() < 800);
      hold_sender = 1'b1;
      wait (expected_results.size() == 0);
      hold_sender = 1'b0;
      wait (pending_items.size() == 0 && !sending);
      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
hw/rtl/rau_pkg.sv
hw/rtl/rau_div_cell.sv
hw/rtl/rau_div_chain.sv
hw/rtl/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_tb.sv
